// ----- rtl/core/deo_pkg.sv -----
// Shared types and constants for the domino Euler path orderer.
// Depends on nothing; used by the top level and the testbench.
package deo_pkg;
   typedef struct packed {
      logic [2:0] left_pips;
      logic [2:0] right_pips;
      logic       last_domino;
   } req_type;

   typedef struct packed {
      logic [6:0] domino_number;
      logic       flipped;
      logic       no_solution;
      logic       last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_CHECK, ST_PUSH0, ST_TOP, ST_SCAN, ST_SCAN_CHK, ST_POP,
      ST_EMIT_RD, ST_EMIT, ST_FAIL, ST_CLEAR
   } state_type;

   localparam logic [2:0] PIP_VALUES = 3'd7;
endpackage

// ----- rtl/core/domino_euler_path_orderer.sv -----
// Domino Euler path orderer: top level, control and walk sequencer.
// Depends on deo_pkg and deo_ram.
//
// Dominoes load while idle. The two adjacency entries of a stored domino
// share one write port, so the input stalls in the cycle after each stored
// domino. The final domino starts the run: a degree check of each pip value,
// a push of the start frame, then a Hierholzer walk over the adjacency memory
// with a scan read and a check per adjacency entry examined and the empty
// scan, the pop and the read of the frame below per stack pop, then the
// results, each a path read and an emit that waits while the output is
// stalled, then a used-mark clear of MAX_DOMINOES entries. The input stalls
// from the final domino to the end of the clear. Each adjacency entry carries
// the flip of its domino as seen from its own list. The walk stack and the
// placed path share one memory: the stack grows up from address 0 and the
// path fills down from the top address. A domino beyond capacity or with a
// half of 7 makes the run report one result with no_solution set.
module domino_euler_path_orderer #(
   parameter int MAX_DOMINOES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deo_pkg::rsp_type rsp_data
);
   import deo_pkg::*;

   localparam int IW = (MAX_DOMINOES > 1) ? $clog2(MAX_DOMINOES) : 1;
   localparam int CW = $clog2(MAX_DOMINOES + 1);
   localparam int LD = 2 * MAX_DOMINOES;
   localparam int LW = $clog2(LD + 1);
   localparam int AW = $clog2(7 * LD);
   localparam int SD = MAX_DOMINOES + 1;
   localparam int SW = $clog2(SD + 1);
   localparam int SAW = $clog2(SD);
   localparam int EW = 3 + IW + 1;
   localparam int FW = 3 + IW + 2;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] acnt_ff [7];
   logic [7:0]    deg_ff  [7];
   logic [MAX_DOMINOES-1:0] used_ff;
   logic [2:0]    k_ff, k_in;
   logic [2:0]    start_ff, start_in;
   logic          start_ok_ff, start_ok_in;
   logic [1:0]    odd_ff, odd_in;
   logic          odd_many_ff, odd_many_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [CW-1:0] plen_ff, plen_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [FW-1:0] top_ff, top_in;
   logic [IW-1:0] clr_ff, clr_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          ad2_ff;
   logic [AW-1:0] ad2_addr_ff;
   logic [EW-1:0] ad2_data_ff;

   // memories
   logic           ad_we;
   logic [AW-1:0]  ad_wa, ad_ra;
   logic [EW-1:0]  ad_wd, ad_rd;
   logic           st_we;
   logic [SAW-1:0] st_wa, st_ra;
   logic [FW-1:0]  st_wd, st_rd;

   deo_ram #(.WIDTH(EW), .DEPTH(7 * LD)) u_adj (
      .clock, .wr_en(ad_we), .wr_addr(ad_wa), .wr_data(ad_wd),
      .rd_addr(ad_ra), .rd_data(ad_rd));
   deo_ram #(.WIDTH(FW), .DEPTH(SD)) u_stack (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   logic           accept;
   logic           load_ok;
   logic           store;
   logic [IW-1:0]  new_id;
   logic [2:0]     lp, rp;
   logic [2:0]     top_v;
   logic [IW-1:0]  ent_id;
   logic [2:0]     ent_to;
   logic           ent_flip;
   logic           ent_free;
   logic           push_ok;
   logic           rsp_free;
   logic           adj_empty;
   logic [SAW-1:0] path_addr;
   logic [SAW-1:0] emit_addr;

   function automatic logic [AW-1:0] adj_addr(input logic [2:0] v, input logic [LW-1:0] i);
      adj_addr = AW'(AW'(v) * AW'(LD) + AW'(i));
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD) || ad2_ff;
   assign load_ok   = (req_data.left_pips != PIP_VALUES) &&
                      (req_data.right_pips != PIP_VALUES) &&
                      (count_ff < CW'(MAX_DOMINOES));
   assign store     = accept && load_ok;
   assign new_id    = count_ff[IW-1:0];
   assign lp        = req_data.left_pips;
   assign rp        = req_data.right_pips;
   assign top_v     = top_ff[FW-2 -: 3];
   assign ent_id    = ad_rd[IW:1];
   assign ent_to    = ad_rd[EW-1 -: 3];
   assign ent_flip  = ad_rd[0];
   assign ent_free  = !used_ff[ent_id];
   assign push_ok   = (sp_ff < SW'(SD));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign adj_empty = (acnt_ff[top_v] == '0);
   assign path_addr = SAW'(SW'(SD - 1) - SW'(plen_ff));
   assign emit_addr = SAW'(SW'(SD) - SW'(plen_ff) + SW'(emit_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (accept && req_data.last_domino) state_in = ST_CHECK;
         ST_CHECK:    if (k_ff == 3'd6) state_in = ST_PUSH0;
         ST_PUSH0:    state_in = (ovf_ff || !start_ok_ff || odd_many_ff || odd_ff == 2'd1)
                                 ? ST_FAIL : ST_SCAN;
         ST_TOP:      state_in = (sp_ff == '0) ? ((plen_ff == count_ff && plen_ff != '0)
                                 ? ST_EMIT_RD : ST_FAIL) : ST_SCAN;
         ST_SCAN:     state_in = (adj_empty || top_v == PIP_VALUES) ? ST_POP : ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = ent_free ? (push_ok ? ST_SCAN : ST_POP) : ST_SCAN;
         ST_POP:      state_in = ST_TOP;
         ST_EMIT_RD:  state_in = ST_EMIT;
         ST_EMIT:     if (rsp_free) state_in = (emit_ff + CW'(1) == plen_ff) ? ST_CLEAR : ST_EMIT_RD;
         ST_FAIL:     if (rsp_free) state_in = ST_CLEAR;
         ST_CLEAR:    if (clr_ff == IW'(MAX_DOMINOES - 1)) state_in = ST_LOAD;
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;  ovf_in = ovf_ff;   k_in = k_ff;
      start_in = start_ff;  start_ok_in = start_ok_ff;
      odd_in = odd_ff;      odd_many_in = odd_many_ff;
      sp_in = sp_ff;        plen_in = plen_ff; emit_in = emit_ff;
      top_in = top_ff;      clr_in = clr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ad_ra = '0;
      st_we = 1'b0; st_wa = sp_ff[SAW-1:0]; st_wd = '0; st_ra = '0;
      unique case (state_ff)
         ST_LOAD: begin
            k_in = '0; start_ok_in = 1'b0; odd_in = '0; odd_many_in = 1'b0;
            if (accept) begin
               if (load_ok) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            k_in = k_ff + 3'd1;
            if (deg_ff[k_ff][0]) begin
               start_in = k_ff; start_ok_in = 1'b1;
               if (odd_ff == 2'd2) odd_many_in = 1'b1; else odd_in = odd_ff + 2'd1;
            end else if (!start_ok_ff && deg_ff[k_ff] != '0) begin
               start_in = k_ff; start_ok_in = 1'b1;
            end
         end
         ST_PUSH0: begin
            st_we = 1'b1; st_wa = '0;
            st_wd = FW'({start_ff, {(IW + 1){1'b0}}});
            top_in = FW'({start_ff, {(IW + 1){1'b0}}});
            sp_in = SW'(1); plen_in = '0; emit_in = '0;
         end
         ST_TOP: begin
            if (sp_ff != '0) begin
               top_in = st_rd;
            end
         end
         ST_SCAN: begin
            if (!adj_empty && top_v != PIP_VALUES) begin
               ad_ra = adj_addr(top_v, acnt_ff[top_v] - LW'(1));
            end
         end
         ST_SCAN_CHK: begin
            if (ent_free && push_ok) begin
               st_we = 1'b1;
               st_wd = {1'b1, ent_to, ent_id, ent_flip};
               top_in = {1'b1, ent_to, ent_id, ent_flip};
               sp_in = sp_ff + SW'(1);
            end
         end
         ST_POP: begin
            sp_in = sp_ff - SW'(1);
            st_ra = (sp_ff > SW'(1)) ? SAW'(sp_ff - SW'(2)) : '0;
            if (top_ff[FW-1] && plen_ff < CW'(MAX_DOMINOES)) begin
               st_we = 1'b1; st_wa = path_addr; st_wd = top_ff;
               plen_in = plen_ff + CW'(1);
            end
         end
         ST_EMIT_RD: begin
            st_ra = emit_addr;
         end
         ST_EMIT: begin
            st_ra = emit_addr;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.domino_number = 7'(st_rd[IW:1]) + 7'd1;
               rsp_in.flipped = st_rd[0];
               rsp_in.no_solution = 1'b0;
               rsp_in.last_result = (emit_ff + CW'(1) == plen_ff);
               emit_in = emit_ff + CW'(1);
            end
         end
         ST_FAIL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{domino_number: '0, flipped: 1'b0, no_solution: 1'b1,
                          last_result: 1'b1};
            end
         end
         ST_CLEAR: begin
            clr_in = (clr_ff == IW'(MAX_DOMINOES - 1)) ? '0 : clr_ff + IW'(1);
            count_in = '0; ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   // adjacency writes share one port: the second entry goes in the stall cycle
   always_comb begin
      ad_we = store || ad2_ff;
      ad_wa = ad2_ff ? ad2_addr_ff : adj_addr(lp, acnt_ff[lp]);
      ad_wd = ad2_ff ? ad2_data_ff : {rp, new_id, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ad2_ff <= 1'b0;
      end else begin
         ad2_ff <= store;
      end
      ad2_addr_ff <= adj_addr(rp, acnt_ff[rp] + ((lp == rp) ? LW'(1) : LW'(0)));
      ad2_data_ff <= {lp, new_id, lp != rp};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0; ovf_ff <= 1'b0; used_ff <= '0;
         rsp_valid_ff <= 1'b0; clr_ff <= '0;
         for (int i = 0; i < 7; i++) begin
            acnt_ff[i] <= '0; deg_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in; clr_ff <= clr_in;
         if (store) begin
            if (lp == rp) begin
               acnt_ff[lp] <= acnt_ff[lp] + LW'(2);
               deg_ff[lp] <= deg_ff[lp] + 8'd2;
            end else begin
               acnt_ff[lp] <= acnt_ff[lp] + LW'(1);
               acnt_ff[rp] <= acnt_ff[rp] + LW'(1);
               deg_ff[lp] <= deg_ff[lp] + 8'd1;
               deg_ff[rp] <= deg_ff[rp] + 8'd1;
            end
         end
         if (state_ff == ST_SCAN && !adj_empty && top_v != PIP_VALUES) begin
            acnt_ff[top_v] <= acnt_ff[top_v] - LW'(1);
         end
         if (state_ff == ST_SCAN_CHK && ent_free && push_ok) begin
            used_ff[ent_id] <= 1'b1;
         end
         if (state_ff == ST_CLEAR) begin
            used_ff[clr_ff] <= 1'b0;
            for (int i = 0; i < 7; i++) begin
               acnt_ff[i] <= '0; deg_ff[i] <= '0;
            end
         end
      end
      k_ff <= k_in; start_ff <= start_in; start_ok_ff <= start_ok_in;
      odd_ff <= odd_in; odd_many_ff <= odd_many_in;
      sp_ff <= sp_in; plen_ff <= plen_in; emit_ff <= emit_in;
      top_ff <= top_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data));
   a_second_write_stall: assert property (@(posedge clock) disable iff (reset)
      ad2_ff |-> req_stall);
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DOMINOES));
   a_stack_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (sp_ff != '0) && (sp_ff <= SW'(SD)));
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_solution |-> rsp_data.last_result &&
      rsp_data.domino_number == '0);
endmodule

// ----- rtl/core/deo_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module deo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- tb/tb_top.sv -----
// Testbench for domino_euler_path_orderer: drives sets of dominoes and checks
// each Euler path result against an in-bench Hierholzer walk predictor.
// Depends on deo_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_top;
   import deo_pkg::*;

   localparam int MAX_SET = 64;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   domino_euler_path_orderer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [5:0]  halves [MAX_SET];
   logic [8:0]  adj [7][2*MAX_SET];
   int          adj_cnt [7];
   int          deg [7];
   bit          used [MAX_SET];
   int          set_size;
   bit          rejected;

   req_type     pending_dominoes [$];
   rsp_type     expected_path [$];
   int          errors = 0;
   int          dominoes_sent = 0;
   int          sets_sent = 0;
   int          paths_seen = 0;
   int          fails_seen = 0;

   function automatic void clear_set();
      for (int k = 0; k < 7; k++) begin
         adj_cnt[k] = 0;
         deg[k] = 0;
      end
      for (int k = 0; k < MAX_SET; k++) used[k] = 0;
      set_size = 0;
      rejected = 0;
   endfunction

   function automatic void add_adj(int v, int other, int id);
      if (v < 7 && adj_cnt[v] < 2*MAX_SET) begin
         adj[v][adj_cnt[v]] = {other[2:0], id[5:0]};
         adj_cnt[v]++;
      end
   endfunction

   function automatic void predict_path(req_type d);
      int odd, start, plen, sp, v, id, to, flip;
      bit fail, found;
      logic [8:0] ent;
      logic [10:0] frames [MAX_SET+1];
      logic [6:0] placed [MAX_SET];
      rsp_type r;
      odd = 0;
      start = -1;
      plen = 0;
      if (d.left_pips == 7 || d.right_pips == 7 || set_size >= MAX_SET) begin
         rejected = 1;
      end else begin
         halves[set_size] = {d.left_pips, d.right_pips};
         add_adj(d.left_pips, d.right_pips, set_size);
         add_adj(d.right_pips, d.left_pips, set_size);
         deg[d.left_pips]++;
         deg[d.right_pips]++;
         set_size++;
      end
      if (!d.last_domino) return;
      for (int k = 0; k < 7; k++) begin
         if (deg[k] % 2 == 1) begin
            odd++;
            start = k;
         end
         if (start < 0 && deg[k] > 0) start = k;
      end
      fail = rejected || start < 0 || !(odd == 0 || odd == 2);
      if (!fail) begin
         sp = 0;
         frames[sp++] = {1'b0, start[2:0], 7'd0};
         while (sp > 0) begin
            v = int'(frames[sp-1][9:7]);
            found = 0;
            while (v < 7 && adj_cnt[v] > 0) begin
               adj_cnt[v]--;
               ent = adj[v][adj_cnt[v]];
               if (!used[ent[5:0]]) begin
                  found = 1;
                  break;
               end
            end
            if (found && sp < MAX_SET + 1) begin
               id = int'(ent[5:0]);
               to = int'(ent[8:6]);
               flip = (halves[id][5:3] == v) ? 0 : 1;
               used[id] = 1;
               frames[sp++] = {1'b1, to[2:0], id[5:0], flip[0]};
            end else begin
               sp--;
               if (frames[sp][10] && plen < MAX_SET) placed[plen++] = frames[sp][6:0];
            end
         end
         if (plen != set_size) fail = 1;
      end
      if (fail) begin
         r = '{domino_number: 7'd0, flipped: 1'b0, no_solution: 1'b1, last_result: 1'b1};
         expected_path.insert(expected_path.size(), r);
      end else begin
         for (int k = 0; k < plen; k++) begin
            r.domino_number = placed[plen-1-k][6:1] + 7'd1;
            r.flipped = placed[plen-1-k][0];
            r.no_solution = 1'b0;
            r.last_result = (k + 1 == plen);
            expected_path.insert(expected_path.size(), r);
         end
      end
      clear_set();
   endfunction

   function automatic void queue_domino(int l, int r, bit last);
      req_type d;
      d.left_pips = 3'(l);
      d.right_pips = 3'(r);
      d.last_domino = last;
      pending_dominoes.insert(pending_dominoes.size(), d);
      dominoes_sent++;
      if (last) sets_sent++;
   endfunction

   // a chain 0-1, 1-2, ... with random content and random flips, optionally broken
   function automatic void queue_chain(int len, bit broken);
      int a, b;
      a = $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
         b = $urandom_range(0, 6);
         if (broken && k == len - 1) b = $urandom_range(0, 7);
         if ($urandom_range(0, 1)) queue_domino(a, b, k == len - 1);
         else queue_domino(b, a, k == len - 1);
         a = b;
      end
   endfunction

   function automatic void queue_random_set(int len);
      for (int k = 0; k < len; k++)
         queue_domino($urandom_range(0, 7), $urandom_range(0, 7), k == len - 1);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_path(req_data);
            send_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (pending_dominoes.size() > 0 && (!req_valid || !req_stall)) begin
               if (req_valid && !req_stall || !req_valid) begin
                  req_data <= pending_dominoes.pop_front();
                  req_valid <= 1;
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   int hold_cycles = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_data.no_solution) fails_seen++;
            else paths_seen++;
            if (expected_path.size() == 0) begin
               $error("unexpected transfer %h", rsp_data);
               errors++;
            end else begin
               want = expected_path.pop_front();
               if (rsp_data.domino_number !== want.domino_number) begin
                  $error("domino_number exp %0d got %0d", want.domino_number,
                         rsp_data.domino_number);
                  errors++;
               end
               if (rsp_data.flipped !== want.flipped) begin
                  $error("flipped exp %0d got %0d", want.flipped, rsp_data.flipped);
                  errors++;
               end
               if (rsp_data.no_solution !== want.no_solution) begin
                  $error("no_solution exp %0d got %0d", want.no_solution,
                         rsp_data.no_solution);
                  errors++;
               end
               if (rsp_data.last_result !== want.last_result) begin
                  $error("last_result exp %0d got %0d", want.last_result,
                         rsp_data.last_result);
                  errors++;
               end
            end
            hold_cycles = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      clear_set();
      // directed
      queue_domino(3, 3, 1);
      queue_domino(0, 6, 1);
      queue_domino(6, 0, 0);
      queue_domino(0, 6, 1);
      queue_domino(0, 1, 0);
      queue_domino(1, 2, 0);
      queue_domino(2, 0, 1);
      queue_domino(0, 1, 0);
      queue_domino(2, 3, 1);
      queue_domino(0, 1, 0);
      queue_domino(0, 2, 0);
      queue_domino(0, 3, 1);
      queue_domino(7, 2, 1);
      queue_domino(4, 7, 1);
      queue_domino(5, 5, 0);
      queue_domino(5, 4, 0);
      queue_domino(4, 4, 1);
      // beyond capacity
      for (int k = 0; k < 65; k++) queue_domino(2, 2, k == 64);
      // random
      while (dominoes_sent < 130) begin
         case ($urandom_range(0, 9))
            0: queue_random_set($urandom_range(1, 6));
            1: queue_chain($urandom_range(1, 10), 1);
            default: queue_chain($urandom_range(1, 12), 0);
         endcase
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      wait (pending_dominoes.size() == 0 && !req_valid);
      wait (expected_path.size() == 0);
      repeat (200) @(posedge clock);
      $display("sets %0d, dominoes %0d, path steps %0d, no-solution runs %0d",
               sets_sent, dominoes_sent, paths_seen, fails_seen);
      if (errors == 0 && expected_path.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("status: fail");
      $finish;
   end
endmodule
